@@ sv/byte_range_lock_table_macros.svh @@
// Assertion macros shared by the checker.
`ifndef BYTE_RANGE_LOCK_TABLE_MACROS_SVH
`define BYTE_RANGE_LOCK_TABLE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BRLT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define BRLT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/brlt_pkg.sv @@
package brlt_pkg;

    localparam int INODE_SLOTS     = 8;
    localparam int LOCKS_PER_INODE = 16;
    localparam int SLOT_W  = (INODE_SLOTS > 1) ? $clog2(INODE_SLOTS) : 1;
    localparam int ENT_W   = (LOCKS_PER_INODE > 1) ? $clog2(LOCKS_PER_INODE) : 1;
    localparam int CNT_W   = $clog2(LOCKS_PER_INODE + 1);
    localparam int DEPTH   = INODE_SLOTS * LOCKS_PER_INODE;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Stored entry: start, len, type, whence, pid.
    localparam int ENTRY_W = 64 + 64 + 2 + 2 + 22;

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    // Request code with no operation behind it.
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] F_RDLCK = 2'd0;
    localparam logic [1:0] F_WRLCK = 2'd1;
    localparam logic [1:0] F_UNLCK = 2'd2;

    localparam logic [1:0] WHENCE_SET = 2'd0;
    localparam logic [1:0] WHENCE_CUR = 2'd1;
    localparam logic [1:0] WHENCE_END = 2'd2;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_CONFLICT = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED  = 3'd4;
    localparam logic [2:0] ST_NOROOM   = 3'd5;

    typedef struct packed {
        logic [63:0] start;
        logic [63:0] len;
        logic [1:0]  ltype;
        logic [1:0]  whence;
        logic [21:0] pid;
    } entry_t;

endpackage

@@ sv/brlt_ram.sv @@
module brlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/byte_range_lock_table.sv @@
// Byte-range lock table. A request is taken when s_valid and s_ready are high and
// gives exactly one result on the m_ channel. s_ready is high only while the block
// is idle, so it stays low from a request transfer until the cycle after its result
// transfer. Every request first walks the inode slots, one per cycle, and then
// decides. A create or search then walks the slot's entries in the entry memory,
// reading each entry and then comparing it for overlap, and ends the walk in a
// read state that finds no more entries; a create with no overlap walks the entries
// again the same way for the lowest unlocked one, and a grant is written in the
// write state. A remove or an unmatched search gives its result from the decision
// alone; a search hit or a conflict at entry k ends the walk there, a create
// overwrites its own overlapping entry k, and a create that finds no unlocked entry
// is appended after the slot's n entries. The entry memory needs no clearing pass:
// only entries below each slot's count are used.
module byte_range_lock_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [30:0] s_inode,
    input  logic [63:0] s_range_start,
    input  logic [63:0] s_range_len,
    input  logic [1:0]  s_lock_type_in,
    input  logic [1:0]  s_whence_in,
    input  logic [63:0] s_seek_pos,
    input  logic [62:0] s_file_size,
    input  logic [21:0] s_owner_pid,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_slot_index,
    output logic [3:0]  m_entry_index,
    output logic [63:0] m_lock_start,
    output logic [63:0] m_lock_len,
    output logic [1:0]  m_lock_type,
    output logic [1:0]  m_lock_whence,
    output logic [21:0] m_lock_pid
);
    import brlt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FIND  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_CMP   = 9'b000001000,
        S_FREE  = 9'b000010000,
        S_FCHK  = 9'b000100000,
        S_WRITE = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;

    // Request registers.
    logic [1:0]  kind_reg;
    logic [30:0] inode_reg;
    logic [63:0] st_reg, ln_reg, seek_reg;
    logic [62:0] fsz_reg;
    logic [1:0]  ty_reg, wh_reg;
    logic [21:0] pid_reg;

    // Slot table in flip-flops.
    logic [INODE_SLOTS-1:0] in_use_reg;
    logic [30:0]            inode_tab_reg [INODE_SLOTS];
    logic [CNT_W-1:0]       count_reg [INODE_SLOTS];

    // Walk state.
    logic [SLOT_W:0]    sidx_reg;
    logic               match_ok_reg, free_ok_reg;
    logic [SLOT_W-1:0]  match_reg, free_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [CNT_W-1:0]   eidx_reg;
    logic [ENT_W-1:0]   hit_reg;

    // Result register.
    logic [2:0]        res_status_reg;
    logic [ENT_W-1:0]  res_ent_reg;
    logic              res_has_entry_reg;
    entry_t            res_entry_reg;
    logic              out_valid_reg;

    // Entry memory.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;

    assign ram_rdata = entry_t'(ram_rbits);

    brlt_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    logic [CNT_W-1:0] cur_count;
    assign cur_count = count_reg[slot_reg];

    logic eidx_more;
    assign eidx_more = (eidx_reg < cur_count);

    function automatic logic [ADDR_W-1:0] addr_of(logic [SLOT_W-1:0] s, logic [ENT_W-1:0] e);
        logic [ADDR_W+ENT_W:0] a;
        a = (ADDR_W + ENT_W + 1)'(s) * (ADDR_W + ENT_W + 1)'(LOCKS_PER_INODE)
            + (ADDR_W + ENT_W + 1)'(e);
        return a[ADDR_W-1:0];
    endfunction

    assign ram_raddr = addr_of(slot_reg, eidx_reg[ENT_W-1:0]);
    assign ram_we    = (state_reg == S_WRITE);
    assign ram_waddr = addr_of(slot_reg, hit_reg);
    assign ram_wdata = '{start: st_reg, len: ln_reg, ltype: ty_reg, whence: wh_reg,
                         pid: pid_reg};

    // Overlap test of the entry just read against the request.
    logic [63:0] base, bend, rend;
    logic        ovl;
    always_comb begin
        base = ram_rdata.start;
        if (ram_rdata.whence == WHENCE_CUR) begin
            base = ram_rdata.start + seek_reg;
        end else if (ram_rdata.whence == WHENCE_END) begin
            base = ram_rdata.start + {1'b0, fsz_reg};
        end
        bend = base + ram_rdata.len;
        rend = st_reg + ln_reg;
        if (ram_rdata.len == 64'd0) begin
            ovl = (ln_reg == 64'd0) || ($signed(base) < $signed(rend));
        end else if (ln_reg == 64'd0) begin
            ovl = $signed(st_reg) < $signed(bend);
        end else begin
            ovl = ($signed(st_reg) < $signed(bend)) && ($signed(base) < $signed(rend));
        end
    end

    logic [SLOT_W-1:0] sidx_lo;
    assign sidx_lo = sidx_reg[SLOT_W-1:0];

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            in_use_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < INODE_SLOTS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        kind_reg  <= s_kind;
                        inode_reg <= s_inode;
                        st_reg    <= s_range_start;
                        ln_reg    <= s_range_len;
                        ty_reg    <= s_lock_type_in;
                        wh_reg    <= s_whence_in;
                        seek_reg  <= s_seek_pos;
                        fsz_reg   <= s_file_size;
                        pid_reg   <= s_owner_pid;
                        sidx_reg  <= '0;
                        match_ok_reg <= 1'b0;
                        free_ok_reg  <= 1'b0;
                        state_reg <= S_FIND;
                    end
                end
                S_FIND: begin
                    // One slot a cycle: first match and lowest free slot.
                    if (!match_ok_reg && in_use_reg[sidx_lo]
                        && inode_tab_reg[sidx_lo] == inode_reg) begin
                        match_ok_reg <= 1'b1;
                        match_reg    <= sidx_lo;
                    end
                    if (!free_ok_reg && !in_use_reg[sidx_lo]) begin
                        free_ok_reg <= 1'b1;
                        free_reg    <= sidx_lo;
                    end
                    sidx_reg <= sidx_reg + 1'b1;
                    if (sidx_reg == (SLOT_W + 1)'(INODE_SLOTS - 1)) begin
                        state_reg <= S_DONE;
                        // Resolve on the first pass through DONE.
                    end
                end
                S_DONE: begin
                    // Decide after the slot walk (sidx_reg marks walk end).
                    if (sidx_reg == (SLOT_W + 1)'(INODE_SLOTS)) begin
                        sidx_reg <= '0;
                        res_has_entry_reg <= 1'b0;
                        res_ent_reg <= '0;
                        eidx_reg <= '0;
                        case (kind_reg)
                            KIND_CREATE: begin
                                if (match_ok_reg) begin
                                    slot_reg  <= match_reg;
                                    state_reg <= S_SCAN;
                                end else if (free_ok_reg) begin
                                    slot_reg <= free_reg;
                                    in_use_reg[free_reg]    <= 1'b1;
                                    inode_tab_reg[free_reg] <= inode_reg;
                                    count_reg[free_reg]     <= '0;
                                    state_reg <= S_SCAN;
                                end else begin
                                    slot_reg <= '0;
                                    res_status_reg <= ST_NOROOM;
                                    out_valid_reg  <= 1'b1;
                                    state_reg <= S_OUT;
                                end
                            end
                            KIND_SEARCH: begin
                                slot_reg <= match_ok_reg ? match_reg : '0;
                                if (match_ok_reg) begin
                                    state_reg <= S_SCAN;
                                end else begin
                                    res_status_reg <= ST_NOTFOUND;
                                    out_valid_reg  <= 1'b1;
                                    state_reg <= S_OUT;
                                end
                            end
                            KIND_REMOVE: begin
                                slot_reg <= match_ok_reg ? match_reg : '0;
                                if (match_ok_reg) begin
                                    in_use_reg[match_reg] <= 1'b0;
                                    count_reg[match_reg]  <= '0;
                                    res_status_reg <= ST_REMOVED;
                                end else begin
                                    res_status_reg <= ST_NOTFOUND;
                                end
                                out_valid_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            default: begin
                                slot_reg <= '0;
                                res_status_reg <= ST_NOTFOUND;
                                out_valid_reg  <= 1'b1;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end else begin
                        sidx_reg <= (SLOT_W + 1)'(INODE_SLOTS);
                    end
                end
                S_SCAN: begin
                    // Read of entry eidx_reg issued this cycle.
                    if (eidx_more) begin
                        state_reg <= S_CMP;
                    end else if (kind_reg == KIND_SEARCH) begin
                        res_status_reg <= ST_NOTFOUND;
                        out_valid_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        eidx_reg  <= '0;
                        state_reg <= S_FREE;
                    end
                end
                S_CMP: begin
                    if (ram_rdata.ltype != F_UNLCK && ovl) begin
                        if (kind_reg == KIND_SEARCH || ram_rdata.pid != pid_reg) begin
                            res_status_reg <= (kind_reg == KIND_SEARCH) ? ST_FOUND
                                                                         : ST_CONFLICT;
                            res_ent_reg       <= eidx_reg[ENT_W-1:0];
                            res_entry_reg     <= ram_rdata;
                            res_has_entry_reg <= 1'b1;
                            out_valid_reg     <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            hit_reg   <= eidx_reg[ENT_W-1:0];
                            state_reg <= S_WRITE;
                        end
                    end else begin
                        eidx_reg  <= eidx_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_FREE: begin
                    if (eidx_more) begin
                        state_reg <= S_FCHK;
                    end else if (cur_count >= CNT_W'(LOCKS_PER_INODE)) begin
                        res_status_reg <= ST_NOROOM;
                        out_valid_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        hit_reg <= cur_count[ENT_W-1:0];
                        count_reg[slot_reg] <= cur_count + 1'b1;
                        state_reg <= S_WRITE;
                    end
                end
                S_FCHK: begin
                    if (ram_rdata.ltype == F_UNLCK) begin
                        hit_reg   <= eidx_reg[ENT_W-1:0];
                        state_reg <= S_WRITE;
                    end else begin
                        eidx_reg  <= eidx_reg + 1'b1;
                        state_reg <= S_FREE;
                    end
                end
                S_WRITE: begin
                    res_status_reg    <= ST_GRANTED;
                    res_ent_reg       <= hit_reg;
                    res_entry_reg     <= ram_wdata;
                    res_has_entry_reg <= 1'b1;
                    out_valid_reg     <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Result channel.
    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_status      = res_status_reg;
    assign m_slot_index  = 3'(slot_reg);
    assign m_entry_index = res_has_entry_reg ? 4'(res_ent_reg) : 4'd0;
    assign m_lock_start  = res_has_entry_reg ? res_entry_reg.start  : 64'd0;
    assign m_lock_len    = res_has_entry_reg ? res_entry_reg.len    : 64'd0;
    assign m_lock_type   = res_has_entry_reg ? res_entry_reg.ltype  : 2'd0;
    assign m_lock_whence = res_has_entry_reg ? res_entry_reg.whence : 2'd0;
    assign m_lock_pid    = res_has_entry_reg ? res_entry_reg.pid    : 22'd0;
endmodule

@@ sv/brlt_checker.sv @@
module brlt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic [3:0] m_entry_index
);
    import brlt_pkg::*;
`include "byte_range_lock_table_macros.svh"

    // Results that carry no entry.
    logic no_entry;
    assign no_entry = (m_status == ST_NOTFOUND) || (m_status == ST_REMOVED)
                      || (m_status == ST_NOROOM);

    // A request is never taken while a result is pending.
    `BRLT_ASSERT(a_no_overlap, aclk, aresetn, (m_valid |-> !s_ready), "accept while result pending")
    // Every accepted request leaves the block busy on the next cycle.
    `BRLT_ASSERT(a_busy, aclk, aresetn, (s_valid && s_ready |=> !s_ready), "ready after transfer")
    // Results with no entry report entry index zero.
    `BRLT_ASSERT(a_idx, aclk, aresetn, (m_valid && no_entry |-> m_entry_index == 4'd0), "entry index")
    // A held result keeps its status.
    `BRLT_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready |=> m_valid && $stable(m_status)), "result dropped")
    // Nothing is shown during reset.
    `BRLT_ASSERT_ALWAYS(a_rst, aclk, (!aresetn |=> !m_valid), "valid after reset")
endmodule

bind byte_range_lock_table brlt_checker u_brlt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_entry_index (m_entry_index)
);
